// ===== rtl/core/ivm_pkg.sv =====
// ---------------------------------------------------------------------------
// ivm_pkg
// Shared defaults for the inverse-variance weighted mean datapath.
// ---------------------------------------------------------------------------
package ivm_pkg;

   // default width of one value or error field, Q16.16
   localparam int VALUE_WIDTH_DEF = 32;

   // width of one stream beat rounded up to whole bytes
   function automatic int byte_round(input int bits);
      return ((bits + 7) / 8) * 8;
   endfunction

endpackage

// ===== rtl/core/ivm_front.sv =====
// ---------------------------------------------------------------------------
// ivm_front
// Squares, cross products and signed numerator over four register stages.
// ---------------------------------------------------------------------------
module ivm_front #(
   parameter int VALUE_WIDTH = ivm_pkg::VALUE_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [VALUE_WIDTH-1:0]     first_value,
   input  logic [VALUE_WIDTH-1:0]     first_sigma,
   input  logic [VALUE_WIDTH-1:0]     second_value,
   input  logic [VALUE_WIDTH-1:0]     second_sigma,
   output logic                       out_valid,
   output logic [3*VALUE_WIDTH-1:0]   mag,
   output logic                       neg,
   output logic [2*VALUE_WIDTH:0]     sum_sq,
   output logic [2*VALUE_WIDTH-1:0]   prod_ab,
   output logic                       zero_sigma
);

   localparam int W = VALUE_WIDTH;

   // stage 1: squares and magnitudes
   logic           v1_ff;
   logic [2*W-1:0] ea2_ff, eb2_ff, ab1_ff;
   logic [W-1:0]   ma1_ff, mb1_ff;
   logic           na1_ff, nb1_ff, z1_ff;
   // stage 2: partial products and sum of squares
   logic           v2_ff;
   logic [2*W-1:0] pal_ff, pah_ff, pbl_ff, pbh_ff, ab2_ff;
   logic [2*W:0]   s2_ff;
   logic           na2_ff, nb2_ff, z2_ff;
   // stage 3: full products
   logic           v3_ff;
   logic [3*W-1:0] pa3_ff, pb3_ff;
   logic [2*W-1:0] ab3_ff;
   logic [2*W:0]   s3_ff;
   logic           na3_ff, nb3_ff, z3_ff;
   // stage 4: signed magnitude of the numerator
   logic           v4_ff;
   logic [3*W-1:0] mag4_ff;
   logic [2*W-1:0] ab4_ff;
   logic [2*W:0]   s4_ff;
   logic           neg4_ff, z4_ff;

   logic [W-1:0]   ma_in, mb_in;
   logic [3*W-1:0] mag_in;
   logic           neg_in;

   assign ma_in = first_value[W-1]  ? (~first_value  + W'(1)) : first_value;
   assign mb_in = second_value[W-1] ? (~second_value + W'(1)) : second_value;

   always_comb begin
      if (na3_ff == nb3_ff) begin
         mag_in = pa3_ff + pb3_ff;
         neg_in = na3_ff;
      end else if (pa3_ff >= pb3_ff) begin
         mag_in = pa3_ff - pb3_ff;
         neg_in = na3_ff;
      end else begin
         mag_in = pb3_ff - pa3_ff;
         neg_in = nb3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ea2_ff <= first_sigma * first_sigma;
         eb2_ff <= second_sigma * second_sigma;
         ab1_ff <= first_sigma * second_sigma;
         ma1_ff <= ma_in;
         mb1_ff <= mb_in;
         na1_ff <= first_value[W-1];
         nb1_ff <= second_value[W-1];
         z1_ff  <= (first_sigma == '0) || (second_sigma == '0);

         pal_ff <= ma1_ff * eb2_ff[W-1:0];
         pah_ff <= ma1_ff * eb2_ff[2*W-1:W];
         pbl_ff <= mb1_ff * ea2_ff[W-1:0];
         pbh_ff <= mb1_ff * ea2_ff[2*W-1:W];
         s2_ff  <= {1'b0, ea2_ff} + {1'b0, eb2_ff};
         ab2_ff <= ab1_ff;
         na2_ff <= na1_ff;
         nb2_ff <= nb1_ff;
         z2_ff  <= z1_ff;

         pa3_ff <= {pah_ff, {W{1'b0}}} + {{W{1'b0}}, pal_ff};
         pb3_ff <= {pbh_ff, {W{1'b0}}} + {{W{1'b0}}, pbl_ff};
         ab3_ff <= ab2_ff;
         s3_ff  <= s2_ff;
         na3_ff <= na2_ff;
         nb3_ff <= nb2_ff;
         z3_ff  <= z2_ff;

         mag4_ff <= mag_in;
         neg4_ff <= neg_in;
         ab4_ff  <= ab3_ff;
         s4_ff   <= s3_ff;
         z4_ff   <= z3_ff;
      end
   end

   assign out_valid  = v4_ff;
   assign mag        = mag4_ff;
   assign neg        = neg4_ff;
   assign sum_sq     = s4_ff;
   assign prod_ab    = ab4_ff;
   assign zero_sigma = z4_ff;

endmodule

// ===== rtl/core/ivm_sqrt.sv =====
// ---------------------------------------------------------------------------
// ivm_sqrt
// Pipelined floored square root, one result bit per register stage.
// ---------------------------------------------------------------------------
module ivm_sqrt #(
   parameter int IN_W   = 66,
   parameter int SIDE_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [IN_W-1:0]   radicand,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [IN_W/2-1:0] root,
   output logic [SIDE_W-1:0] side_out
);

   localparam int RW = IN_W / 2;

   logic              vld_ff  [RW];
   logic [RW:0]       rem_ff  [RW];
   logic [RW-1:0]     root_ff [RW];
   logic [IN_W-1:0]   rad_ff  [RW];
   logic [SIDE_W-1:0] side_ff [RW];

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic              vld_prev;
      logic [RW:0]       rem_prev;
      logic [RW-1:0]     root_prev;
      logic [IN_W-1:0]   rad_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [RW+2:0]     cur;
      logic [RW+2:0]     trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = '0;
         assign root_prev = '0;
         assign rad_prev  = radicand;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev  = rad_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign cur   = {rem_prev, rad_prev[IN_W-1:IN_W-2]};
      assign trial = {1'b0, root_prev, 2'b01};
      assign ge    = cur >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? (RW+1)'(cur - trial) : cur[RW:0];
            root_ff[k] <= {root_prev[RW-2:0], ge};
            rad_ff[k]  <= rad_prev << 2;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[RW-1];
   assign root      = root_ff[RW-1];
   assign side_out  = side_ff[RW-1];

endmodule

// ===== rtl/core/ivm_div.sv =====
// ---------------------------------------------------------------------------
// ivm_div
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient must fit QUO_W bits.
// ---------------------------------------------------------------------------
module ivm_div #(
   parameter int NUM_W  = 96,
   parameter int DEN_W  = 65,
   parameter int QUO_W  = 32,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   input  logic [SIDE_W-1:0] side_in,
   output logic              out_valid,
   output logic [QUO_W-1:0]  quo,
   output logic [SIDE_W-1:0] side_out
);

   logic              vld_ff  [QUO_W];
   logic [DEN_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  low_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   logic [SIDE_W-1:0] side_ff [QUO_W];

   logic [NUM_W-1:0] num_top;

   assign num_top = num >> QUO_W;

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic              vld_prev;
      logic [DEN_W-1:0]  rem_prev;
      logic [QUO_W-1:0]  low_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic [DEN_W-1:0]  den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic [DEN_W:0]    trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign vld_prev  = in_valid;
         assign rem_prev  = DEN_W'(num_top);
         assign low_prev  = num[QUO_W-1:0];
         assign quo_prev  = '0;
         assign den_prev  = den;
         assign side_prev = side_in;
      end else begin : g_next
         assign vld_prev  = vld_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign low_prev  = low_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial = {rem_prev, low_prev[QUO_W-1]};
      assign ge    = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
            low_ff[k]  <= low_prev << 1;
            quo_ff[k]  <= {quo_prev[QUO_W-2:0], ge};
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign quo       = quo_ff[QUO_W-1];
   assign side_out  = side_ff[QUO_W-1];

endmodule

// ===== rtl/core/inverse_variance_mean.sv =====
// ---------------------------------------------------------------------------
// inverse_variance_mean
// Inverse-variance weighted mean of two measurements per bin.
// ---------------------------------------------------------------------------
// Each transaction on the req_ channel carries one bin: two signed Q16.16
// values and their unsigned errors. The block returns on the rsp_ channel
// the weighted mean (a*B^2 + b*A^2)/(A^2+B^2), truncated toward zero, and the
// combined error A*B/floor(sqrt(A^2+B^2)), floored, exactly one result per
// bin and in order. If either error is zero both results are zero and
// rsp_tuser is set. The datapath is a fixed pipeline: four stages of
// squares and products, VALUE_WIDTH+1 square-root stages, VALUE_WIDTH
// divider stages and an output register. One bin is taken every cycle
// while no finished result waits on rsp_tready. The whole pipeline holds
// while a finished result waits on rsp_tready.
// ---------------------------------------------------------------------------
module inverse_variance_mean #(
   parameter int VALUE_WIDTH = ivm_pkg::VALUE_WIDTH_DEF
) (
   input  logic clock,
   input  logic reset,
   // first_value, first_sigma, second_value, second_sigma (lowest bits first)
   input  logic [ivm_pkg::byte_round(4*VALUE_WIDTH)-1:0] req_tdata,
   input  logic                                          req_tvalid,
   output logic                                          req_tready,
   // mean_value, mean_sigma (lowest bits first)
   output logic [ivm_pkg::byte_round(2*VALUE_WIDTH)-1:0] rsp_tdata,
   // zero_sigma
   output logic                                          rsp_tuser,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready
);

   localparam int W      = VALUE_WIDTH;
   localparam int RSP_W  = ivm_pkg::byte_round(2*VALUE_WIDTH);
   localparam int SQ_IN  = 2*W + 2;
   // side payload through the root: mag, neg, zero, prod_ab, sum_sq
   localparam int SIDE_W = 3*W + 2 + 2*W + 2*W + 1;

   // one enable for every stage: advance unless a result is stuck
   logic pipe_en;

   // front end
   logic           fr_valid;
   logic [3*W-1:0] fr_mag;
   logic           fr_neg;
   logic [2*W:0]   fr_sum;
   logic [2*W-1:0] fr_ab;
   logic           fr_zero;

   // root stage
   logic              sq_valid;
   logic [W:0]        sq_root;
   logic [SIDE_W-1:0] sq_side_in, sq_side_out;
   logic [3*W-1:0]    sq_mag;
   logic              sq_neg, sq_zero;
   logic [2*W-1:0]    sq_ab;
   logic [2*W:0]      sq_sum;

   // divider lanes
   logic         mdiv_valid, sdiv_valid;
   logic [W-1:0] mdiv_quo, sdiv_quo;
   logic [1:0]   mdiv_side;
   logic         sdiv_side;

   // output register
   logic         rsp_valid_ff;
   logic [W-1:0] mean_ff, sigma_ff;
   logic         zero_ff;
   logic [W-1:0] mean_in;

   assign pipe_en    = !rsp_valid_ff || rsp_tready;
   assign req_tready = pipe_en;

   ivm_front #(
      .VALUE_WIDTH(W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .en          (pipe_en),
      .in_valid    (req_tvalid),
      .first_value (req_tdata[W-1:0]),
      .first_sigma (req_tdata[2*W-1:W]),
      .second_value(req_tdata[3*W-1:2*W]),
      .second_sigma(req_tdata[4*W-1:3*W]),
      .out_valid   (fr_valid),
      .mag         (fr_mag),
      .neg         (fr_neg),
      .sum_sq      (fr_sum),
      .prod_ab     (fr_ab),
      .zero_sigma  (fr_zero)
   );

   assign sq_side_in = {fr_sum, fr_ab, fr_zero, fr_neg, fr_mag};

   ivm_sqrt #(
      .IN_W  (SQ_IN),
      .SIDE_W(SIDE_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (fr_valid),
      .radicand ({1'b0, fr_sum}),
      .side_in  (sq_side_in),
      .out_valid(sq_valid),
      .root     (sq_root),
      .side_out (sq_side_out)
   );

   assign {sq_sum, sq_ab, sq_zero, sq_neg, sq_mag} = sq_side_out;

   // mean lane: |numerator| / sum of squares
   ivm_div #(
      .NUM_W (3*W),
      .DEN_W (2*W+1),
      .QUO_W (W),
      .SIDE_W(2)
   ) u_mean_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (sq_valid),
      .num      (sq_mag),
      .den      (sq_sum),
      .side_in  ({sq_zero, sq_neg}),
      .out_valid(mdiv_valid),
      .quo      (mdiv_quo),
      .side_out (mdiv_side)
   );

   // error lane: A*B / floor(sqrt(sum of squares))
   ivm_div #(
      .NUM_W (2*W),
      .DEN_W (W+1),
      .QUO_W (W),
      .SIDE_W(1)
   ) u_sigma_div (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_valid (sq_valid),
      .num      (sq_ab),
      .den      (sq_root),
      .side_in  (sq_zero),
      .out_valid(sdiv_valid),
      .quo      (sdiv_quo),
      .side_out (sdiv_side)
   );

   // restore the sign of the mean
   assign mean_in = mdiv_side[0] ? (~mdiv_quo + W'(1)) : mdiv_quo;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         rsp_valid_ff <= mdiv_valid;
      end
   end

   // zero both results when an error was zero
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         mean_ff  <= mdiv_side[1] ? '0 : mean_in;
         sigma_ff <= mdiv_side[1] ? '0 : sdiv_quo;
         zero_ff  <= mdiv_side[1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({sigma_ff, mean_ff});
   assign rsp_tuser  = zero_ff;

   // both divider lanes advance in lock step
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      (mdiv_valid == sdiv_valid) && (!mdiv_valid || (mdiv_side[1] == sdiv_side)))
      else $error("divider lanes out of step");

   // a flagged result carries zero data
   a_zero_flag_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (mean_ff == '0 && sigma_ff == '0))
      else $error("flagged result has non-zero data");

   // nothing comes out straight after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

   // a held result does not let the pipeline move
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(mean_ff) && $stable(sigma_ff)))
      else $error("pipeline advanced under stall");

endmodule
